[rtl/expression_tokenizer_macros.svh]
// Assertion macros for the expression tokenizer RTL.
// Included by files that carry concurrent assertions; needs a clk and rst_n in scope.
`ifndef EXPRESSION_TOKENIZER_MACROS_SVH
`define EXPRESSION_TOKENIZER_MACROS_SVH

`ifndef SYNTHESIS
// Property checked on every clock edge outside reset
`define EXTOK_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("extok assertion failed");
// Property checked on every clock edge, reset included
`define EXTOK_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("extok assertion failed");
`else
`define EXTOK_ASSERT(lbl, prop)
`define EXTOK_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

[rtl/extok_pkg.sv]
// Shared types and constants of the expression tokenizer.
// No dependencies; used by the interface, lexer, queue and top-level RTL files.
`timescale 1ns / 1ps

package extok_pkg;

  // Longest line, and the saturation point of positions and lengths
  localparam int MAX_LINE = 256;
  localparam int POS_CAP_I = ((MAX_LINE - 1) < 255) ? (MAX_LINE - 1) : 255;
  localparam logic [7:0] POS_CAP = 8'(POS_CAP_I);

  // Result queue sizing: up to three results per character
  localparam int MAX_RES = 3;
  localparam int Q_DEPTH = 8;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_LVL_W = $clog2(Q_DEPTH + 1);
  localparam int Q_ROOM  = Q_DEPTH - MAX_RES;

  typedef enum logic [4:0] {
    K_RESERVED = 5'd0,
    K_PLUS     = 5'd1,
    K_MINUS    = 5'd2,
    K_MUL      = 5'd3,
    K_DIV      = 5'd4,
    K_ASSIGN   = 5'd5,
    K_NUMBER   = 5'd6,
    K_IDENT    = 5'd7,
    K_LSQ      = 5'd8,
    K_RSQ      = 5'd9,
    K_LPAR     = 5'd10,
    K_RPAR     = 5'd11,
    K_FRAC     = 5'd12,
    K_COMMA    = 5'd13,
    K_SEMI     = 5'd14,
    K_ERROR    = 5'd15,
    K_EOL      = 5'd16
  } kind_t;

  typedef enum logic [1:0] {
    W_ABS   = 2'd0,
    W_PRINT = 2'd1,
    W_X     = 2'd2,
    W_NONE  = 2'd3
  } word_t;

  // One result item
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  start_res;
    logic [7:0]  length;
    word_t       word;
    logic        last;
  } tok_t;

  // Results produced by one character, lowest slot first
  typedef struct packed {
    logic [1:0]            cnt;
    tok_t [MAX_RES-1:0]    tok;
  } push_t;

endpackage

[rtl/extok_if.sv]
// Channel interfaces of the expression tokenizer: character input and token output.
// Depends on extok_pkg for the field types.
`timescale 1ns / 1ps

interface extok_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       line_last;

  modport source (output valid, output ch, output line_last, input ready);
  modport sink   (input valid, input ch, input line_last, output ready);
endinterface

interface extok_out_if;
  logic                valid;
  logic                ready;
  extok_pkg::kind_t    kind;
  logic [7:0]          start_res;
  logic [7:0]          length;
  extok_pkg::word_t    word;
  logic                last;

  modport source (output valid, output kind, output start_res, output length,
                  output word, output last, input ready);
  modport sink   (input valid, input kind, input start_res, input length,
                  input word, input last, output ready);
endinterface

[rtl/extok_lexer.sv]
// Lexer core: line state registers and the per-character token logic.
// Depends on extok_pkg; emits up to three results per accepted character.
`timescale 1ns / 1ps

module extok_lexer (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                take,
  input  logic [7:0]          ch,
  input  logic                line_last,
  output extok_pkg::push_t    push
);

  typedef enum logic [2:0] {
    PC_NONE  = 3'd0,
    PC_ALPHA = 3'd1,
    PC_DIGIT = 3'd2,
    PC_SLASH = 3'd3,
    PC_MINUS = 3'd4
  } pclass_t;

  typedef enum logic [3:0] {
    WM_START = 4'd0,
    WM_A     = 4'd1,
    WM_AB    = 4'd2,
    WM_ABS   = 4'd3,
    WM_P     = 4'd4,
    WM_PR    = 4'd5,
    WM_PRI   = 4'd6,
    WM_PRIN  = 4'd7,
    WM_PRINT = 4'd8,
    WM_X     = 4'd9,
    WM_DEAD  = 4'd10
  } wmatch_t;

  // Character codes with a meaning of their own
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LSQ   = 8'h5B;
  localparam logic [7:0] CH_RSQ   = 8'h5D;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MUL   = 8'h2A;
  localparam logic [7:0] CH_EQ    = 8'h3D;

  pclass_t    pc_r, pc_nxt;
  wmatch_t    wm_r, wm_nxt;
  logic [7:0] pos_r, pos_nxt;
  logic [7:0] ts_r, ts_nxt;
  logic [7:0] tl_r, tl_nxt;
  logic       skip_r, skip_nxt;

  function automatic logic [7:0] sat_inc(input logic [7:0] v);
    return (v < extok_pkg::POS_CAP) ? (v + 8'd1) : extok_pkg::POS_CAP;
  endfunction

  function automatic wmatch_t match_next(input wmatch_t m, input logic [7:0] c);
    wmatch_t r;
    r = WM_DEAD;
    case (m)
      WM_START: begin
        if (c == "a") r = WM_A;
        else if (c == "p") r = WM_P;
        else if (c == "X") r = WM_X;
      end
      WM_A:    if (c == "b") r = WM_AB;
      WM_AB:   if (c == "s") r = WM_ABS;
      WM_P:    if (c == "r") r = WM_PR;
      WM_PR:   if (c == "i") r = WM_PRI;
      WM_PRI:  if (c == "n") r = WM_PRIN;
      WM_PRIN: if (c == "t") r = WM_PRINT;
      default: r = WM_DEAD;
    endcase
    return r;
  endfunction

  function automatic extok_pkg::tok_t mk_tok(input extok_pkg::kind_t k,
                                             input logic [7:0] s,
                                             input logic [7:0] l,
                                             input extok_pkg::word_t w);
    extok_pkg::tok_t t;
    t.kind      = k;
    t.start_res = s;
    t.length    = l;
    t.word      = w;
    t.last      = 1'b0;
    return t;
  endfunction

  // Result that closing the open token gives
  function automatic extok_pkg::tok_t close_tok(input pclass_t p, input wmatch_t m,
                                                input logic [7:0] s,
                                                input logic [7:0] l);
    extok_pkg::tok_t t;
    t = mk_tok(extok_pkg::K_IDENT, s, l, extok_pkg::W_NONE);
    case (p)
      PC_ALPHA: begin
        if (m == WM_ABS)        t = mk_tok(extok_pkg::K_RESERVED, s, l, extok_pkg::W_ABS);
        else if (m == WM_PRINT) t = mk_tok(extok_pkg::K_RESERVED, s, l, extok_pkg::W_PRINT);
        else if (m == WM_X)     t = mk_tok(extok_pkg::K_RESERVED, s, l, extok_pkg::W_X);
      end
      PC_DIGIT: t = mk_tok(extok_pkg::K_NUMBER, s, l, extok_pkg::W_NONE);
      PC_SLASH: t = mk_tok(extok_pkg::K_DIV, s, 8'd1, extok_pkg::W_NONE);
      PC_MINUS: t = mk_tok(extok_pkg::K_MINUS, s, 8'd1, extok_pkg::W_NONE);
      default:  t = mk_tok(extok_pkg::K_IDENT, s, l, extok_pkg::W_NONE);
    endcase
    return t;
  endfunction

  // Per-character token logic
  logic             alpha, digit, is_slash, is_minus, is_space, is_single, do_close;
  extok_pkg::kind_t single_k;
  logic [1:0]       n;

  always_comb begin
    pc_nxt   = pc_r;
    wm_nxt   = wm_r;
    pos_nxt  = pos_r;
    ts_nxt   = ts_r;
    tl_nxt   = tl_r;
    skip_nxt = skip_r;
    n        = 2'd0;
    push     = '0;

    alpha    = ((ch >= "A") && (ch <= "Z")) || ((ch >= "a") && (ch <= "z"));
    digit    = (ch >= "0") && (ch <= "9");
    is_slash = (ch == CH_SLASH);
    is_minus = (ch == CH_MINUS);
    is_space = (ch == CH_SPACE);
    is_single = !alpha && !digit && !is_slash && !is_minus && !is_space;

    case (ch)
      CH_LSQ:   single_k = extok_pkg::K_LSQ;
      CH_RSQ:   single_k = extok_pkg::K_RSQ;
      CH_COMMA: single_k = extok_pkg::K_COMMA;
      CH_SEMI:  single_k = extok_pkg::K_SEMI;
      CH_LPAR:  single_k = extok_pkg::K_LPAR;
      CH_RPAR:  single_k = extok_pkg::K_RPAR;
      CH_PLUS:  single_k = extok_pkg::K_PLUS;
      CH_MUL:   single_k = extok_pkg::K_MUL;
      CH_EQ:    single_k = extok_pkg::K_ASSIGN;
      default:  single_k = extok_pkg::K_ERROR;
    endcase

    // Does this character end the open token before its own action
    do_close = !skip_r &&
               ((alpha && (pc_r != PC_ALPHA)) ||
                (digit && (pc_r != PC_DIGIT) && (pc_r != PC_MINUS)) ||
                (is_slash && (pc_r != PC_SLASH)) ||
                is_minus || is_space || is_single);

    if (do_close) begin
      if (pc_nxt != PC_NONE) begin
        push.tok[n] = close_tok(pc_nxt, wm_nxt, ts_nxt, tl_nxt);
        n = n + 2'd1;
      end
      pc_nxt = PC_NONE;
      tl_nxt = 8'd0;
      wm_nxt = WM_START;
    end

    if (!skip_r) begin
      if (alpha) begin
        if (pc_nxt == PC_ALPHA) begin
          tl_nxt = sat_inc(tl_nxt);
        end else begin
          pc_nxt = PC_ALPHA;
          ts_nxt = pos_r;
          tl_nxt = 8'd1;
          wm_nxt = WM_START;
        end
        wm_nxt = match_next(wm_nxt, ch);
      end else if (digit) begin
        if ((pc_nxt == PC_DIGIT) || (pc_nxt == PC_MINUS)) begin
          pc_nxt = PC_DIGIT;
          tl_nxt = sat_inc(tl_nxt);
        end else begin
          pc_nxt = PC_DIGIT;
          ts_nxt = pos_r;
          tl_nxt = 8'd1;
          wm_nxt = WM_START;
        end
      end else if (is_slash) begin
        if (pc_nxt == PC_SLASH) begin
          // second slash: fraction bar
          push.tok[n] = mk_tok(extok_pkg::K_FRAC, ts_nxt, 8'd2, extok_pkg::W_NONE);
          n = n + 2'd1;
          pc_nxt = PC_NONE;
          tl_nxt = 8'd0;
        end else begin
          pc_nxt = PC_SLASH;
          ts_nxt = pos_r;
          tl_nxt = 8'd1;
          wm_nxt = WM_START;
        end
      end else if (is_minus) begin
        pc_nxt = PC_MINUS;
        ts_nxt = pos_r;
        tl_nxt = 8'd1;
        wm_nxt = WM_START;
      end else if (is_single) begin
        push.tok[n] = mk_tok(single_k, pos_r, 8'd1, extok_pkg::W_NONE);
        n = n + 2'd1;
        if (single_k == extok_pkg::K_ERROR) skip_nxt = 1'b1;
      end
    end

    pos_nxt = sat_inc(pos_r);

    // End of line: close, report the line length, back to reset state
    if (line_last) begin
      if (pc_nxt != PC_NONE) begin
        push.tok[n] = close_tok(pc_nxt, wm_nxt, ts_nxt, tl_nxt);
        n = n + 2'd1;
      end
      push.tok[n] = mk_tok(extok_pkg::K_EOL, pos_nxt, 8'd0, extok_pkg::W_NONE);
      n = n + 2'd1;
      pc_nxt   = PC_NONE;
      wm_nxt   = WM_START;
      pos_nxt  = 8'd0;
      ts_nxt   = 8'd0;
      tl_nxt   = 8'd0;
      skip_nxt = 1'b0;
    end

    if (n != 2'd0) push.tok[n - 2'd1].last = 1'b1;
    push.cnt = n;
  end

  // Line state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r   <= PC_NONE;
      wm_r   <= WM_START;
      pos_r  <= 8'd0;
      ts_r   <= 8'd0;
      tl_r   <= 8'd0;
      skip_r <= 1'b0;
    end else if (take) begin
      pc_r   <= pc_nxt;
      wm_r   <= wm_nxt;
      pos_r  <= pos_nxt;
      ts_r   <= ts_nxt;
      tl_r   <= tl_nxt;
      skip_r <= skip_nxt;
    end
  end

endmodule

[rtl/extok_resq.sv]
// Result queue: takes up to three tokens per cycle, hands out one per cycle when popped.
// Depends on extok_pkg for the token type and queue sizing.
`timescale 1ns / 1ps

module extok_resq (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                push_en,
  input  extok_pkg::push_t                    push,
  input  logic                                pop,
  output extok_pkg::tok_t                     head,
  output logic [extok_pkg::Q_LVL_W-1:0]       level
);

  extok_pkg::tok_t                      mem_r [extok_pkg::Q_DEPTH];
  logic [extok_pkg::Q_PTR_W-1:0]        wr_r, wr_nxt;
  logic [extok_pkg::Q_PTR_W-1:0]        rd_r, rd_nxt;
  logic [extok_pkg::Q_LVL_W-1:0]        lvl_r, lvl_nxt;
  logic [1:0]                           add;

  assign add    = push_en ? push.cnt : 2'd0;
  assign wr_nxt = wr_r + extok_pkg::Q_PTR_W'(add);
  assign rd_nxt = rd_r + extok_pkg::Q_PTR_W'(pop);
  assign lvl_nxt = lvl_r + extok_pkg::Q_LVL_W'(add) - extok_pkg::Q_LVL_W'(pop);

  assign head  = mem_r[rd_r];
  assign level = lvl_r;

  // Token storage, written at consecutive slots
  always_ff @(posedge clk) begin
    for (int i = 0; i < extok_pkg::MAX_RES; i++) begin
      if (push_en && (2'(i) < push.cnt)) begin
        mem_r[wr_r + extok_pkg::Q_PTR_W'(i)] <= push.tok[i];
      end
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      lvl_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      lvl_r <= lvl_nxt;
    end
  end

endmodule

[rtl/expression_tokenizer.sv]
// Expression tokenizer: one character per transaction in, tokens out.
// A token is written to the result queue when the character that completes it is accepted.
// Throughput: one character per cycle while in_s.ready is high; results leave at one per cycle
// from an eight-entry queue while out_s.ready is high.
// Input is held off while fewer than three queue entries are free.
// Reset: synchronous, active low; line state cleared and the queue emptied.
`timescale 1ns / 1ps
`include "expression_tokenizer_macros.svh"

module expression_tokenizer (
  input  logic                clk,
  input  logic                rst_n,
  extok_in_if.sink            in_s,
  extok_out_if.source         out_s
);

  logic                               take;
  logic                               pop;
  extok_pkg::push_t                   push;
  extok_pkg::tok_t                    head;
  logic [extok_pkg::Q_LVL_W-1:0]      level;

  // Accept while the queue can absorb a full set of results
  assign in_s.ready = (level <= extok_pkg::Q_LVL_W'(extok_pkg::Q_ROOM));
  assign take       = in_s.valid && in_s.ready;

  extok_lexer u_lexer (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .ch        (in_s.ch),
    .line_last (in_s.line_last),
    .push      (push)
  );

  extok_resq u_resq (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_en (take),
    .push    (push),
    .pop     (pop),
    .head    (head),
    .level   (level)
  );

  // Output side
  assign out_s.valid     = (level != '0);
  assign pop             = out_s.valid && out_s.ready;
  assign out_s.kind      = head.kind;
  assign out_s.start_res = head.start_res;
  assign out_s.length    = head.length;
  assign out_s.word      = head.word;
  assign out_s.last      = head.last;

  // Checks
  `EXTOK_ASSERT(a_level_bound, level <= extok_pkg::Q_LVL_W'(extok_pkg::Q_DEPTH))
  `EXTOK_ASSERT(a_take_has_room, take |-> (level <= extok_pkg::Q_LVL_W'(extok_pkg::Q_ROOM)))
  `EXTOK_ASSERT(a_line_end_result, (take && in_s.line_last) |-> (push.cnt != 2'd0))
  `EXTOK_ASSERT(a_eol_is_last, (out_s.valid && (out_s.kind == extok_pkg::K_EOL)) |-> out_s.last)
  `EXTOK_ASSERT(a_level_step, (!take && !pop) |=> $stable(level))

endmodule
